// ----- src/assert_macros.svh -----
// Assertion macros shared by the keyer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, disabled while reset is low.
`define MCK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define MCK_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `MCK_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ----- src/mck_pkg.sv -----
// Package for the Morse character keyer: entry and segment types, timing
// constants and the character code table. Depends on nothing.
`default_nettype none

package mck_pkg;

    localparam int CODE_MAX    = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam int         K_INDEX      = 10;

    localparam logic [2:0] UNITS_DIT        = 3'd1;
    localparam logic [2:0] UNITS_DAH        = 3'd3;
    localparam logic [2:0] UNITS_GAP        = 3'd1;
    localparam logic [2:0] UNITS_LETTER_END = 3'd2;
    localparam logic [2:0] UNITS_WORD       = 3'd4;

    typedef struct packed {
        logic       space;
        logic [2:0] count;
        logic [4:0] pattern;
    } mck_code_t;

    typedef struct packed {
        logic       key_on;
        logic [2:0] units;
        logic       last;
    } mck_seg_t;

    localparam logic [2:0] ALPHA_LEN [0:25] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [4:0] ALPHA_PAT [0:25] = '{
        5'h02, 5'h07, 5'h05, 5'h03, 5'h01, 5'h0D, 5'h01, 5'h0F, 5'h03,
        5'h08, 5'h02, 5'h0B, 5'h00, 5'h01, 5'h00, 5'h09, 5'h02, 5'h05,
        5'h07, 5'h00, 5'h06, 5'h0E, 5'h04, 5'h06, 5'h04, 5'h03
    };

    localparam logic [4:0] DIGIT_PAT [0:9] = '{
        5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E, 5'h1F, 5'h0F, 5'h07, 5'h03, 5'h01
    };

    // Returns the element code with the first element in the top pattern bit.
    function automatic mck_code_t mck_lookup(logic [7:0] ch);
        mck_code_t  code;
        logic [4:0] alpha_off;
        logic [3:0] digit_off;
        logic [2:0] len;
        logic [4:0] pat;
        alpha_off = 5'(ch - CHAR_UPPER_A);
        digit_off = 4'(ch - CHAR_DIGIT_0);
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            len = ALPHA_LEN[alpha_off];
            pat = ALPHA_PAT[alpha_off];
        end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            len = 3'(CODE_MAX);
            pat = DIGIT_PAT[digit_off];
        end else begin
            len = ALPHA_LEN[K_INDEX];
            pat = ALPHA_PAT[K_INDEX];
        end
        code.space   = (ch == CHAR_SPACE);
        code.count   = len;
        code.pattern = pat << (3'(CODE_MAX) - len);
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- src/mck_front.sv -----
// Front end of the keyer: accepts characters and classifies them into
// element codes for the queue. Depends on mck_pkg.
`default_nettype none

module mck_front (
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,    // [7:0] character
    input  wire logic             q_full,
    output logic                  q_push,
    output mck_pkg::mck_code_t    q_entry
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_entry  = mck_pkg::mck_lookup(s_tdata);

endmodule

`default_nettype wire

// ----- src/mck_queue.sv -----
// Short queue of classified character codes between front and back end.
// Depends on mck_pkg.
`default_nettype none

module mck_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mck_pkg::mck_code_t   push_entry,
    output logic                      full,
    output logic                      not_empty,
    input  wire logic                 pop,
    output mck_pkg::mck_code_t        pop_entry
);

    mck_pkg::mck_code_t                 entries [mck_pkg::QUEUE_DEPTH];
    logic [mck_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [mck_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [mck_pkg::QCNT_W-1:0]         count_reg, count_next;

    assign full      = (count_reg == mck_pkg::QCNT_W'(mck_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == mck_pkg::QPTR_W'(mck_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == mck_pkg::QPTR_W'(mck_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- src/mck_back.sv -----
// Back end of the keyer: steps through one character code and drives the
// segment output register. Depends on mck_pkg.
`default_nettype none

module mck_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_not_empty,
    input  wire mck_pkg::mck_code_t   q_entry,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,    // [0] key_on, [3:1] units, [7:4] zero
    output logic                      m_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SPACE = 5'b00010,
        ST_ELEM  = 5'b00100,
        ST_GAP   = 5'b01000,
        ST_END   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [4:0]          pattern_reg, pattern_next;
    logic [2:0]          remain_reg, remain_next;
    mck_pkg::mck_seg_t   seg;
    mck_pkg::mck_seg_t   out_reg;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;
    logic                fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = (state_reg != ST_IDLE) && out_free;
    assign q_pop    = q_not_empty && ((state_reg == ST_IDLE) || (fire && seg.last));

    always_comb begin
        seg = '0;
        unique case (state_reg)
            ST_SPACE: seg = '{key_on: 1'b0, units: mck_pkg::UNITS_WORD, last: 1'b1};
            ST_ELEM:  seg = '{key_on: 1'b1,
                              units: pattern_reg[4] ? mck_pkg::UNITS_DIT : mck_pkg::UNITS_DAH,
                              last: 1'b0};
            ST_GAP:   seg = '{key_on: 1'b0, units: mck_pkg::UNITS_GAP, last: 1'b0};
            ST_END:   seg = '{key_on: 1'b0, units: mck_pkg::UNITS_LETTER_END, last: 1'b1};
            default:  seg = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        pattern_next = pattern_reg;
        remain_next  = remain_reg;
        if (fire) begin
            unique case (state_reg)
                ST_ELEM: state_next = ST_GAP;
                ST_GAP: begin
                    pattern_next = {pattern_reg[3:0], 1'b0};
                    remain_next  = remain_reg - 1'b1;
                    state_next   = (remain_reg == 3'd1) ? ST_END : ST_ELEM;
                end
                default: state_next = ST_IDLE;
            endcase
        end
        if (q_pop) begin
            state_next   = q_entry.space ? ST_SPACE : ST_ELEM;
            pattern_next = q_entry.pattern;
            remain_next  = q_entry.count;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pattern_reg <= pattern_next;
        remain_reg  <= remain_next;
        if (fire) begin
            out_reg <= seg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.units, out_reg.key_on};
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

// ----- src/morse_character_keyer_top.sv -----
// Top level of the Morse character keyer: front end, code queue and
// segment sequencer. Depends on mck_pkg, mck_front, mck_queue, mck_back.
//
// The s_ channel takes one ASCII character per request in s_tdata[7:0].
// The m_ channel returns keying segments: m_tdata[0] is the key level,
// m_tdata[3:1] the duration in time units, and m_tlast marks the final
// segment of a character. A space gives one key-up segment of 4 units;
// any other character gives key-down/key-up pairs for its elements and
// a closing key-up of 2 units. Codes outside A-Z and 0-9 are sent as K.
// Each character is queued, then the sequencer loads its segments into
// the output register, one per cycle while the receiver accepts; that
// rate sets the sustained throughput. A character gives 1 (space) to 11
// (digits) segments, twice its element count plus one. A two-entry queue
// lets new characters be taken while earlier ones are still keyed out.
// When the receiver stalls, the output register holds its segment, the
// sequencer waits, and s_tready drops once the queue is full.
// Reset empties the queue and the output register; no item is in flight.
`default_nettype none
`include "assert_macros.svh"

module morse_character_keyer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] character
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [0] key_on, [3:1] units, [7:4] zero
    output logic             m_tlast
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_not_empty;
    logic                 q_pop;
    mck_pkg::mck_code_t   push_entry;
    mck_pkg::mck_code_t   pop_entry;

    mck_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    mck_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .pop_entry  (pop_entry)
    );

    mck_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    `MCK_ASSERT(a_last_is_key_up, aclk, aresetn, (m_tvalid && m_tlast) |-> (!m_tdata[0] && (m_tdata[3:1] == mck_pkg::UNITS_LETTER_END || m_tdata[3:1] == mck_pkg::UNITS_WORD)), "final segment must be a key-up of 2 or 4 units")
    `MCK_ASSERT(a_key_down_units, aclk, aresetn, (m_tvalid && m_tdata[0]) |-> (!m_tlast && (m_tdata[3:1] == mck_pkg::UNITS_DIT || m_tdata[3:1] == mck_pkg::UNITS_DAH)), "key-down segment must be a dit or dah")
    `MCK_ASSERT(a_gap_follows_element, aclk, aresetn, (m_tvalid && m_tready && m_tdata[0]) |=> (!m_tvalid || (!m_tdata[0] && m_tdata[3:1] == mck_pkg::UNITS_GAP)), "element must be followed by a one-unit gap")
    `MCK_ASSERT_NEVER(a_no_pop_when_empty, aclk, aresetn, q_pop && !q_not_empty, "queue popped while empty")

endmodule

`default_nettype wire
